FILE: rtl/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // Escape decoder mode
    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_ESCAPE   = 2'd1,
        MODE_HEX_HIGH = 2'd2,
        MODE_HEX_LOW  = 2'd3
    } mode_t;

    // Result kind carried on tuser
    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_END     = 2'd1,
        KIND_UNKNOWN = 2'd2
    } kind_t;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_APOS      = 8'h27;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;

    // One decode step: result and next escape state
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        kind_t      kind;
        mode_t      mode;
        logic [7:0] high_nibble;
    } step_t;

endpackage

`default_nettype wire

FILE: rtl/jsu_decode.sv
`timescale 1ns / 1ps
`default_nettype none

// One character through the escape state machine (combinational).
module jsu_decode
(
    input  wire logic [7:0]     ch,
    input  wire jsu_pkg::mode_t mode,
    input  wire logic [7:0]     high_nibble,
    output jsu_pkg::step_t      step
);

    logic [7:0] hex_val;

    // Hex digit value; non-digits follow the lowercase formula, mod 256
    always_comb
    begin
        if (ch >= 8'h30 && ch <= 8'h39)
            hex_val = ch - 8'd48;
        else if (ch >= 8'h41 && ch <= 8'h46)
            hex_val = ch - 8'd55;
        else
            hex_val = ch - 8'd87;
    end

    always_comb
    begin
        step.emit        = 1'b0;
        step.data        = 8'd0;
        step.kind        = jsu_pkg::KIND_BYTE;
        step.mode        = mode;
        step.high_nibble = high_nibble;
        unique case (mode)
            jsu_pkg::MODE_NORMAL:
            begin
                if (ch == jsu_pkg::CH_QUOTE)
                begin
                    step.emit = 1'b1;
                    step.kind = jsu_pkg::KIND_END;
                end
                else if (ch == jsu_pkg::CH_BACKSLASH)
                    step.mode = jsu_pkg::MODE_ESCAPE;
                else
                begin
                    step.emit = 1'b1;
                    step.data = ch;
                end
            end
            jsu_pkg::MODE_ESCAPE:
            begin
                if (ch == jsu_pkg::CH_X)
                    step.mode = jsu_pkg::MODE_HEX_HIGH;
                else
                begin
                    step.mode = jsu_pkg::MODE_NORMAL;
                    step.emit = 1'b1;
                    unique case (ch)
                        jsu_pkg::CH_SLASH, jsu_pkg::CH_BACKSLASH,
                        jsu_pkg::CH_APOS, jsu_pkg::CH_QUOTE: step.data = ch;
                        8'h62:   step.data = 8'd8;   // b
                        8'h66:   step.data = 8'd12;  // f
                        8'h6E:   step.data = 8'd10;  // n
                        8'h72:   step.data = 8'd13;  // r
                        8'h74:   step.data = 8'd9;   // t
                        8'h76:   step.data = 8'd11;  // v
                        default: step.kind = jsu_pkg::KIND_UNKNOWN;
                    endcase
                end
            end
            jsu_pkg::MODE_HEX_HIGH:
            begin
                step.high_nibble = hex_val;
                step.mode        = jsu_pkg::MODE_HEX_LOW;
            end
            default:
            begin
                // low value is ORed in unmasked
                step.mode = jsu_pkg::MODE_NORMAL;
                step.emit = 1'b1;
                step.data = {high_nibble[3:0], 4'd0} | hex_val;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/json_string_unescape_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// JSON string body unescaper. Feed the characters that follow the opening
// quote, one per input word; each word yields zero or one output word.
// Plain characters come out as is, backslash escapes (\/ \\ \' \" \b \f
// \n \r \t \v and \xHH) come out as the decoded byte, a closing quote gives
// an end-of-string word (tuser = 1, tdata = 0) and any other escape gives an
// unknown-escape word (tuser = 2, tdata = 0). Backslashes, the x of \x and
// first hex digits produce nothing. Throughput is one character per cycle
// while the output is not stalled; each character passes the input register,
// then the result register, with one escape-state update between them. After a
// closing quote the unit is back in plain mode and decodes a new string.
module json_string_unescape_unit
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] char_in
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]      m_axis_tuser    // [1:0] out_kind
);

    // input register
    logic           in_valid_reg;
    logic [7:0]     in_char_reg;
    // escape state
    jsu_pkg::mode_t mode_reg;
    logic [7:0]     high_nibble_reg;
    // result register
    logic           out_valid_reg;
    logic [7:0]     out_data_reg;
    jsu_pkg::kind_t out_kind_reg;

    jsu_pkg::step_t step;
    logic           out_free;
    logic           advance;

    jsu_decode u_decode
    (
        .ch          (in_char_reg),
        .mode        (mode_reg),
        .high_nibble (high_nibble_reg),
        .step        (step)
    );

    // A word that makes no result retires even while the output is stalled.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (out_free || !step.emit);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            mode_reg        <= jsu_pkg::MODE_NORMAL;
            high_nibble_reg <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                mode_reg        <= step.mode;
                high_nibble_reg <= step.high_nibble;
            end
            if (out_free)
                out_valid_reg <= advance && step.emit;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_char_reg <= s_axis_tdata;
        if (out_free && advance && step.emit)
        begin
            out_data_reg <= step.data;
            out_kind_reg <= step.kind;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/jsu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [1:0] m_axis_tuser
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser == jsu_pkg::KIND_BYTE ||
            m_axis_tuser == jsu_pkg::KIND_END || m_axis_tuser == jsu_pkg::KIND_UNKNOWN)
        else $error("illegal result kind");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != jsu_pkg::KIND_BYTE |-> m_axis_tdata == 8'd0)
        else $error("marker word carries nonzero data");

    // input only backs up behind a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
